// File: src/plic_pkg.sv
// Shared widths, request and register codes for the interrupt controller.
package plic_pkg;

  localparam int unsigned SRC_W           = 32;
  localparam int unsigned ID_W            = 5;
  localparam int unsigned PRIO_W          = 3;
  localparam int unsigned REQ_W           = 2;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned NUM_SOURCES_DEF = 32;

  typedef logic [REQ_W-1:0]     req_t;
  typedef logic [ID_W-1:0]      id_t;
  typedef logic [PRIO_W-1:0]    prio_t;
  typedef logic [SRC_W-1:0]     src_vec_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam req_t REQ_LINE     = 2'd0;
  localparam req_t REQ_CLAIM    = 2'd1;
  localparam req_t REQ_COMPLETE = 2'd2;
  localparam req_t REQ_PRIO     = 2'd3;

  localparam cfg_idx_t CFG_ENABLE = 1'b0;
  localparam cfg_idx_t CFG_THRESH = 1'b1;

endpackage

// File: src/plic_if.sv
// Request and response channel interfaces of the interrupt controller.
interface plic_req_if import plic_pkg::*; ();
  logic     valid;
  logic     ready;
  req_t     req_type;
  src_vec_t irq_lines;
  id_t      source_id;
  prio_t    priority_value;

  modport source (output valid, req_type, irq_lines, source_id, priority_value,
                  input ready);
  modport sink (input valid, req_type, irq_lines, source_id, priority_value,
                output ready);
endinterface

interface plic_rsp_if import plic_pkg::*; ();
  logic valid;
  logic ready;
  id_t  claimed_id;
  logic interrupt_request;

  modport source (output valid, claimed_id, interrupt_request, input ready);
  modport sink (input valid, claimed_id, interrupt_request, output ready);
endinterface

// File: src/platform_interrupt_controller.sv
// Top level: single-target platform interrupt controller.
// An accepted request passes the input register and then the result register before its result is offered.
// Throughput: one transaction per cycle unless the result is stalled; a stalled result register holds one
// result and the input register one more transaction before ready drops.
// Reset (rst_n, synchronous, active low) clears pending, in-service, priorities,
// enable mask, threshold and both valid flags.
module platform_interrupt_controller import plic_pkg::*; #(
  parameter int unsigned NUM_SOURCES = NUM_SOURCES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  plic_req_if.sink              in_req,
  plic_rsp_if.source            out_rsp
);

  // Sources beyond the line vector never exist; ID 0 is reserved for "none".
  localparam int unsigned NSRC = (NUM_SOURCES < SRC_W) ? NUM_SOURCES : SRC_W;
  localparam src_vec_t EXISTS = src_vec_t'((64'd1 << NSRC) - 64'd1) & ~src_vec_t'(1);
  localparam int unsigned LVL = $clog2(SRC_W);

  // Configuration registers
  src_vec_t enable_r;
  prio_t    thresh_r;

  // Interrupt state
  prio_t    prio_r [NSRC];
  prio_t    prio_nxt [NSRC];
  src_vec_t pending_r, pending_nxt;
  src_vec_t in_service_r, in_service_nxt;

  // Input register
  logic     s1_valid_r, s1_valid_nxt;
  req_t     s1_req_r;
  src_vec_t s1_lines_r;
  id_t      s1_id_r;
  prio_t    s1_prio_r;

  // Result register
  logic     out_valid_r, out_valid_nxt;
  id_t      out_id_r, out_id_nxt;
  logic     out_irq_r, out_irq_nxt;

  logic     in_fire;
  logic     advance;
  src_vec_t id_bit;

  // Selection tree signals
  prio_t    leaf_prio [SRC_W];
  prio_t    after_prio [SRC_W];
  src_vec_t cand;
  src_vec_t after_gt;
  logic     lv_vld  [LVL+1][SRC_W];
  id_t      lv_id   [LVL+1][SRC_W];
  prio_t    lv_prio [LVL+1][SRC_W];
  logic     best_vld;
  id_t      best_id;
  logic [NSRC-1:0] prio_we;

  // Handshake: the input register moves on whenever the result register
  // is empty or being drained this cycle.
  assign advance       = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready  = !s1_valid_r || advance;
  assign in_fire       = in_req.valid && in_req.ready;

  assign out_rsp.valid             = out_valid_r;
  assign out_rsp.claimed_id        = out_id_r;
  assign out_rsp.interrupt_request = out_irq_r;

  assign id_bit = src_vec_t'(1) << s1_id_r;

  // Per-source priority view, with priority write decode and the
  // priority that stands after this transaction.
  for (genvar g = 0; g < SRC_W; g++) begin : g_src
    if (g < NSRC) begin : g_real
      assign leaf_prio[g]  = prio_r[g];
      assign prio_we[g]    = advance && (s1_req_r == REQ_PRIO) &&
                             (s1_id_r == ID_W'(g)) && EXISTS[g];
      assign prio_nxt[g]   = prio_we[g] ? s1_prio_r : prio_r[g];
      assign after_prio[g] = prio_nxt[g];
    end else begin : g_none
      assign leaf_prio[g]  = '0;
      assign after_prio[g] = '0;
    end
    assign after_gt[g] = after_prio[g] > thresh_r;
  end

  // Candidates: pending, enabled and existing; the threshold test is applied at the tree leaves.
  assign cand = pending_r & enable_r & EXISTS;

  // Tournament over all sources: the left (lower ID) side keeps ties.
  always_comb begin
    for (int l = 0; l <= LVL; l++) begin
      for (int k = 0; k < SRC_W; k++) begin
        lv_vld[l][k]  = 1'b0;
        lv_id[l][k]   = '0;
        lv_prio[l][k] = '0;
      end
    end
    for (int k = 0; k < SRC_W; k++) begin
      lv_vld[0][k]  = cand[k] && (leaf_prio[k] > thresh_r);
      lv_id[0][k]   = ID_W'(k);
      lv_prio[0][k] = leaf_prio[k];
    end
    for (int l = 0; l < LVL; l++) begin
      for (int k = 0; k < (SRC_W >> (l + 1)); k++) begin
        if (lv_vld[l][2*k] &&
            (!lv_vld[l][2*k+1] || lv_prio[l][2*k] >= lv_prio[l][2*k+1])) begin
          lv_vld[l+1][k]  = 1'b1;
          lv_id[l+1][k]   = lv_id[l][2*k];
          lv_prio[l+1][k] = lv_prio[l][2*k];
        end else begin
          lv_vld[l+1][k]  = lv_vld[l][2*k+1];
          lv_id[l+1][k]   = lv_id[l][2*k+1];
          lv_prio[l+1][k] = lv_prio[l][2*k+1];
        end
      end
    end
  end

  assign best_vld = lv_vld[LVL][0];
  assign best_id  = lv_id[LVL][0];

  // Apply the held transaction to the pending and in-service vectors.
  always_comb begin
    pending_nxt    = pending_r;
    in_service_nxt = in_service_r;
    out_id_nxt     = '0;
    if (advance) begin
      unique case (s1_req_r)
        REQ_LINE: begin
          pending_nxt = pending_r | (s1_lines_r & ~in_service_r & EXISTS);
        end
        REQ_CLAIM: begin
          if (best_vld) begin
            out_id_nxt     = best_id;
            pending_nxt    = pending_r & ~(src_vec_t'(1) << best_id);
            in_service_nxt = in_service_r | (src_vec_t'(1) << best_id);
          end
        end
        REQ_COMPLETE: begin
          // Complete only counts for an existing, enabled source.
          if ((EXISTS & enable_r & id_bit) != '0) begin
            in_service_nxt = in_service_r & ~id_bit;
          end
        end
        default: begin
          // Priority write: handled by the per-source decode.
        end
      endcase
    end
  end

  // Request line reflects the state after this transaction.
  assign out_irq_nxt = |(pending_nxt & enable_r & EXISTS & after_gt);

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= '0;
      thresh_r     <= '0;
      pending_r    <= '0;
      in_service_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NSRC; i++) begin
        prio_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE: enable_r <= cfg_wdata;
          CFG_THRESH: thresh_r <= cfg_wdata[PRIO_W-1:0];
          default:    enable_r <= enable_r;
        endcase
      end
      pending_r    <= pending_nxt;
      in_service_r <= in_service_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      for (int i = 0; i < NSRC; i++) begin
        prio_r[i] <= prio_nxt[i];
      end
    end
  end

  // Payload registers: input on acceptance, result on advance; hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r   <= in_req.req_type;
      s1_lines_r <= in_req.irq_lines;
      s1_id_r    <= in_req.source_id;
      s1_prio_r  <= in_req.priority_value;
    end
    if (advance) begin
      out_id_r  <= out_id_nxt;
      out_irq_r <= out_irq_nxt;
    end
  end

endmodule

// File: src/plic_checker.sv
// Port-level checker for the interrupt controller, bound to the top level.
module plic_checker import plic_pkg::*; #(
  parameter int unsigned NUM_SOURCES = NUM_SOURCES_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input id_t  out_claimed_id,
  input logic out_interrupt_request
);

  // Stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_claimed_id) && $stable(out_interrupt_request))
    else $error("result changed while stalled");

  // Input back-pressure only arises from a stalled, full result register.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // A granted ID always names an existing source.
  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_claimed_id != '0 |-> 32'(out_claimed_id) < NUM_SOURCES)
    else $error("claimed ID beyond the implemented sources");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind platform_interrupt_controller plic_checker #(.NUM_SOURCES(NUM_SOURCES)) u_plic_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_ready              (in_req.ready),
  .out_valid             (out_rsp.valid),
  .out_ready             (out_rsp.ready),
  .out_claimed_id        (out_rsp.claimed_id),
  .out_interrupt_request (out_rsp.interrupt_request)
);
